// ===== rtl/bal_pkg.sv =====
// ----------------------------------------------------------------------------
// bal_pkg: shared types and constants
// Slot table depth, status codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package bal_pkg;

  localparam int unsigned SLOTS      = 256;
  localparam int unsigned MIN_ALIGN  = 8;
  localparam int unsigned IDX_W      = $clog2(SLOTS);
  localparam int unsigned CNT_W      = IDX_W + 1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOSLOT   = 2'd1;
  localparam logic [1:0] ST_NOPOOL   = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic       KIND_ALLOC  = 1'b0;
  localparam logic       KIND_FREE   = 1'b1;

  localparam logic [1:0] CFG_PAGE_SHIFT = 2'd0;
  localparam logic [1:0] CFG_POOL_BASE  = 2'd1;
  localparam logic [1:0] CFG_POOL_BYTES = 2'd2;

  typedef struct packed {
    logic load;      // capture request, start
    logic rd_last;   // read entry slot_count-1
    logic calc;      // compute aligned offset
    logic append;    // write new entry
    logic srch_rd;   // read mid entry
    logic srch_step; // evaluate mid entry
    logic hi_rd;     // read hi entry
    logic retire;    // zero size of found entry
    logic trim_rd;   // read top entry
    logic trim_chk;  // evaluate top entry
  } bal_cmd_t;

  typedef struct packed {
    logic is_free;
    logic cnt_zero;
    logic cnt_full;
    logic no_pool;
    logic hit;       // mid entry matches
    logic go_hi;     // address above mid, lo == mid
    logic srch_done; // lo >= hi after step
    logic hi_hit;
    logic trim_more; // top entry freed and top > 0
    logic need_trim; // retired entry is newest
    logic idx_zero;  // retired entry is the first
  } bal_sts_t;

endpackage

// ===== rtl/bal_if.sv =====
// ----------------------------------------------------------------------------
// bal_req_if / bal_rsp_if: request and response channels
// Valid/ready channels carrying allocator requests and responses.
// ----------------------------------------------------------------------------
interface bal_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] size;
  logic [31:0] address;
  modport source (output valid, kind, size, address, input ready);
  modport sink   (input valid, kind, size, address, output ready);
endinterface

interface bal_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_address;
  logic [1:0]  status;
  modport source (output valid, block_address, status, input ready);
  modport sink   (input valid, block_address, status, output ready);
endinterface

// ===== rtl/bal_datapath.sv =====
// ----------------------------------------------------------------------------
// bal_datapath: slot table and arithmetic
// Holds the slot memories, count, search bounds and alignment math.
// ----------------------------------------------------------------------------
module bal_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bal_pkg::bal_cmd_t          cmd,
  output bal_pkg::bal_sts_t          sts,
  input  logic                       req_kind,
  input  logic [31:0]                req_size,
  input  logic [31:0]                req_address,
  input  logic [4:0]                 page_shift,
  input  logic [31:0]                pool_base,
  input  logic [31:0]                pool_bytes,
  output logic [31:0]                res_addr
);

  logic [31:0] addr_mem [bal_pkg::SLOTS];
  logic [31:0] size_mem [bal_pkg::SLOTS];

  logic [bal_pkg::CNT_W-1:0] cnt_r;
  logic [bal_pkg::IDX_W-1:0] lo_r, hi_r, idx_r;
  logic                      kind_r;
  logic [31:0]               size_r, addr_r;
  logic [31:0]               rd_addr_r, rd_size_r;
  logic [33:0]               used_r;
  logic [31:0]               res_r;

  logic [bal_pkg::IDX_W-1:0] rd_idx;
  logic [bal_pkg::IDX_W-1:0] mid;
  logic [bal_pkg::IDX_W:0]   mid_sum;
  logic [bal_pkg::IDX_W-1:0] last_idx;
  logic [32:0]               page;
  logic [32:0]               align;
  logic [33:0]               sum;
  logic [33:0]               used_nxt;
  logic [31:0]               rel;

  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = mid_sum[bal_pkg::IDX_W:1];
  assign last_idx = bal_pkg::IDX_W'(cnt_r - 1'b1);
  assign page     = 33'd1 << page_shift;
  assign rel      = rd_addr_r - pool_base;

  always_comb begin
    align = 33'(bal_pkg::MIN_ALIGN);
    if ({1'b0, size_r} >= page) begin
      align = page;
    end else begin
      for (int k = 32; k >= $clog2(bal_pkg::MIN_ALIGN); k--) begin
        if ({1'b0, size_r} <= (33'd1 << k)) align = 33'd1 << k;
      end
    end
    sum      = {2'b0, rel} + {2'b0, rd_size_r} + {1'b0, align} - 34'd1;
    used_nxt = sum & ~({1'b0, align} - 34'd1);
  end

  always_comb begin
    rd_idx = idx_r;
    if (cmd.rd_last)      rd_idx = last_idx;
    else if (cmd.srch_rd) rd_idx = mid;
    else if (cmd.hi_rd)   rd_idx = hi_r;
    else if (cmd.trim_rd) rd_idx = idx_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= addr_mem[rd_idx];
    rd_size_r <= size_mem[rd_idx];
    if (cmd.append) begin
      addr_mem[cnt_r[bal_pkg::IDX_W-1:0]] <= pool_base + used_r[31:0];
      size_mem[cnt_r[bal_pkg::IDX_W-1:0]] <= size_r;
    end else if (cmd.retire) begin
      size_mem[idx_r] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.append) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (cmd.retire && sts.need_trim) begin
      cnt_r <= {1'b0, idx_r};
    end else if (cmd.trim_chk && rd_size_r == '0) begin
      cnt_r <= {1'b0, idx_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= req_kind;
      size_r <= req_size;
      addr_r <= req_address;
      lo_r   <= '0;
      hi_r   <= last_idx;
      used_r <= '0;
    end
    if (cmd.calc) used_r <= used_nxt;
    if (cmd.rd_last) idx_r <= last_idx;
    if (cmd.srch_rd) idx_r <= mid;
    if (cmd.srch_step) begin
      if (addr_r > rd_addr_r) lo_r <= idx_r;
      else if (addr_r != rd_addr_r) hi_r <= idx_r;
    end
    if (cmd.hi_rd) idx_r <= hi_r;
    if (cmd.retire) idx_r <= idx_r - 1'b1;
    if (cmd.trim_chk && rd_size_r == '0) idx_r <= idx_r - 1'b1;
    if (cmd.append) res_r <= pool_base + used_r[31:0];
  end

  assign sts.is_free   = kind_r;
  assign sts.cnt_zero  = cnt_r == '0;
  assign sts.cnt_full  = cnt_r >= bal_pkg::CNT_W'(bal_pkg::SLOTS);
  assign sts.no_pool   = used_r > {2'b0, pool_bytes} ||
                         {2'b0, size_r} > ({2'b0, pool_bytes} - used_r);
  assign sts.hit       = rd_addr_r == addr_r;
  assign sts.go_hi     = addr_r > rd_addr_r && lo_r == idx_r;
  assign sts.srch_done = addr_r > rd_addr_r ? (idx_r >= hi_r) : (lo_r >= idx_r);
  assign sts.hi_hit    = rd_addr_r == addr_r;
  assign sts.trim_more = rd_size_r == '0 && idx_r != '0;
  assign sts.need_trim = {1'b0, idx_r} + 1'b1 == cnt_r;
  assign sts.idx_zero  = idx_r == '0;
  assign res_addr      = res_r;

endmodule

// ===== rtl/bal_ctrl.sv =====
// ----------------------------------------------------------------------------
// bal_ctrl: request sequencer
// Steps allocation, bisection search and trim walk through the datapath.
// ----------------------------------------------------------------------------
module bal_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic                res_ok,
  output bal_pkg::bal_cmd_t   cmd,
  input  bal_pkg::bal_sts_t   sts
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DISP  = 11'b00000000010,
    S_LRD   = 11'b00000000100,
    S_CALC  = 11'b00000001000,
    S_CHK   = 11'b00000010000,
    S_SRD   = 11'b00000100000,
    S_SSTEP = 11'b00001000000,
    S_HCHK  = 11'b00010000000,
    S_RET   = 11'b00100000000,
    S_TCHK  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] st_r, st_nxt;
  logic       ok_r, ok_nxt;
  logic       trim_r, trim_nxt;

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    ok_nxt    = ok_r;
    trim_nxt  = trim_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        ok_nxt = 1'b0;
        if (!sts.is_free) begin
          if (sts.cnt_full) begin
            st_nxt = bal_pkg::ST_NOSLOT; state_nxt = S_DONE;
          end else if (sts.cnt_zero) begin
            state_nxt = S_CHK;
          end else begin
            cmd.rd_last = 1'b1; state_nxt = S_LRD;
          end
        end else if (sts.cnt_zero) begin
          st_nxt = bal_pkg::ST_NOTFOUND; state_nxt = S_DONE;
        end else begin
          cmd.srch_rd = 1'b1; state_nxt = S_SRD;
        end
      end
      S_LRD: state_nxt = S_CALC;
      S_CALC: begin
        cmd.calc = 1'b1; state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.no_pool) begin
          st_nxt = bal_pkg::ST_NOPOOL;
        end else begin
          cmd.append = 1'b1; st_nxt = bal_pkg::ST_OK; ok_nxt = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_SRD: state_nxt = S_SSTEP;
      S_SSTEP: begin
        cmd.srch_step = 1'b1;
        if (sts.hit) begin
          state_nxt = S_RET;
        end else if (sts.go_hi) begin
          cmd.hi_rd = 1'b1; state_nxt = S_HCHK;
        end else if (sts.srch_done) begin
          st_nxt = bal_pkg::ST_NOTFOUND; state_nxt = S_DONE;
        end else begin
          state_nxt = S_DISP;
        end
      end
      S_HCHK: begin
        if (trim_r) begin
          if (sts.hi_hit) state_nxt = S_RET;
          else begin
            st_nxt = bal_pkg::ST_NOTFOUND; state_nxt = S_DONE;
          end
          trim_nxt = 1'b0;
        end else begin
          trim_nxt = 1'b1;
        end
      end
      S_RET: begin
        cmd.retire = 1'b1;
        st_nxt     = bal_pkg::ST_OK;
        if (sts.need_trim && !sts.idx_zero) begin
          cmd.trim_rd = 1'b1; state_nxt = S_TCHK; trim_nxt = 1'b0;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_TCHK: begin
        if (trim_r) begin
          cmd.trim_chk = 1'b1;
          trim_nxt     = 1'b0;
          if (sts.trim_more) state_nxt = S_TCHK;
          else state_nxt = S_DONE;
        end else begin
          trim_nxt = 1'b1;
        end
      end
      S_DONE: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= bal_pkg::ST_OK;
      ok_r    <= 1'b0;
      trim_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      ok_r    <= ok_nxt;
      trim_r  <= trim_nxt;
    end
  end

  assign in_ready   = state_r == S_IDLE;
  assign out_valid  = state_r == S_DONE;
  assign out_status = st_r;
  assign res_ok     = ok_r;

  a_hs_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready during result");
  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && res_ok |-> out_status == bal_pkg::ST_OK) else $error("ok mismatch");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)) else $error("result dropped");

endmodule

// ===== rtl/bump_allocator_with_lifo_free.sv =====
// ----------------------------------------------------------------------------
// bump_allocator_with_lifo_free: stack bump allocator with sorted slot table
// One request at a time; an allocation reads the newest entry, aligns and
// checks the pool, a free bisects the table and may trim trailing entries.
// ----------------------------------------------------------------------------
// A request is taken when the block is idle and answered with exactly one
// response. An allocation runs a dispatch step, a read of the newest entry
// and one alignment/add step (both skipped when the table is empty), then
// one pool check. A free runs a bisection over the table, each probe being
// a dispatch, a memory read and a compare, plus, when needed, a final check
// of the upper entry; when the newest entry is freed and is not the first,
// a trim walk follows over the trailing freed entries. The next request is
// taken once the response has been accepted.
module bump_allocator_with_lifo_free (
  input  logic        clk,
  input  logic        rst_n,
  bal_req_if.sink     in_ch,
  bal_rsp_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [4:0]  page_shift_r;
  logic [31:0] pool_base_r, pool_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_shift_r <= 5'd12;
      pool_base_r  <= '0;
      pool_bytes_r <= 32'd1048576;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bal_pkg::CFG_PAGE_SHIFT: page_shift_r <= cfg_data[4:0];
        bal_pkg::CFG_POOL_BASE:  pool_base_r  <= cfg_data;
        bal_pkg::CFG_POOL_BYTES: pool_bytes_r <= cfg_data;
        default: ;
      endcase
    end
  end

  bal_pkg::bal_cmd_t cmd;
  bal_pkg::bal_sts_t sts;
  logic              res_ok;
  logic [31:0]       res_addr;

  bal_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_status(out_ch.status),
    .res_ok,
    .cmd, .sts
  );

  bal_datapath u_dp (
    .clk, .rst_n, .cmd, .sts,
    .req_kind   (in_ch.kind),
    .req_size   (in_ch.size),
    .req_address(in_ch.address),
    .page_shift (page_shift_r),
    .pool_base  (pool_base_r),
    .pool_bytes (pool_bytes_r),
    .res_addr
  );

  assign out_ch.block_address = res_ok ? res_addr : 32'd0;

endmodule
